// ===== hdl/gbfp_pkg.sv =====
package gbfp_pkg;

   typedef enum logic [3:0] {
      MODE_WORD    = 4'd0,
      MODE_IDLE    = 4'd1,
      MODE_SYNC    = 4'd2,
      MODE_CLASS   = 4'd3,
      MODE_ID      = 4'd4,
      MODE_LEN_LO  = 4'd5,
      MODE_LEN_HI  = 4'd6,
      MODE_PAYLOAD = 4'd7,
      MODE_CK_A    = 4'd8,
      MODE_CK_B    = 4'd9
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_WORD   = 3'd1,
      EV_HEADER = 3'd2,
      EV_DATA   = 3'd3,
      EV_OK     = 3'd4,
      EV_CKA    = 3'd5,
      EV_CKB    = 3'd6,
      EV_LONG   = 3'd7
   } event_type;

   localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND     = 8'h62;
   localparam logic [2:0]  WORD_LEN        = 3'd6;
   localparam logic [15:0] LEN_LIMIT_RESET = 16'd1024;

   function automatic logic [7:0] word_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h4E;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  frame_class;
      logic [7:0]  frame_id;
      logic [15:0] frame_len;
      logic [7:0]  data_byte;
      logic [15:0] data_index;
   } result_type;

endpackage

// ===== hdl/gnss_binary_frame_parser_top.sv =====
// Receive-side frame parser for a byte stream from a serial receiver.
// Request channel: req_valid/req_ready with one byte on req_rx_byte.
// Result channel: rsp_valid/rsp_ready; each request gives exactly one result
// with an event code (none, start word, header, payload byte, frame ok,
// checksum A or B fail, length over limit) and the current frame fields.
// csr_write_enable/csr_write_data set the largest accepted payload length.
// A request is first held in the input register; the parse step then writes
// its result into the result register, which drives the result channel.
// Throughput: one request per cycle while results are taken; the parse
// state updates once per byte, so the step logic between the two registers
// sets the rate.
// Reset: the parser hunts for the start word, all frame fields read zero,
// the length limit is 1024, and both registers are empty.
// Stall: when the result is not taken, the result register holds, the
// input register holds its byte, and req_ready drops only once both are
// full; a new request is accepted in the same cycle a result leaves.
module gnss_binary_frame_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_frame_class,
   output logic [7:0]  rsp_frame_id,
   output logic [15:0] rsp_frame_len,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_data_index,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic                 advance;
   logic                 fire;
   logic                 byte_valid;
   logic [7:0]           byte_data;
   gbfp_pkg::result_type result;
   gbfp_pkg::result_type rsp_data;

   gbfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   gbfp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .rx_byte          (byte_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (result)
   );

   gbfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .result     (result),
      .advance    (advance),
      .fire       (fire),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_event_res   = rsp_data.event_res;
   assign rsp_frame_class = rsp_data.frame_class;
   assign rsp_frame_id    = rsp_data.frame_id;
   assign rsp_frame_len   = rsp_data.frame_len;
   assign rsp_data_byte   = rsp_data.data_byte;
   assign rsp_data_index  = rsp_data.data_index;

endmodule

// ===== hdl/gbfp_in_reg.sv =====
module gbfp_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = req_ready ? req_valid : valid_ff;
   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

// ===== hdl/gbfp_core.sv =====
module gbfp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_write_enable,
   input  logic [15:0]            csr_write_data,
   output gbfp_pkg::result_type   result
);

   gbfp_pkg::mode_type mode_ff, mode_in;
   logic [2:0]  word_pos_ff, word_pos_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [15:0] max_len_ff;
   logic [15:0] count_inc;
   logic [7:0]  acc_a;

   gbfp_pkg::event_type ev;
   logic [7:0]  dbyte;
   logic [15:0] dindex;

   assign count_inc = count_ff + 16'd1;
   assign acc_a     = sum_a_ff + rx_byte;

   always_comb begin
      mode_in     = mode_ff;
      word_pos_in = word_pos_ff;
      count_in    = count_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      len_in      = len_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      ev          = gbfp_pkg::EV_NONE;
      dbyte       = 8'd0;
      dindex      = 16'd0;

      if (mode_ff >= gbfp_pkg::MODE_CLASS && mode_ff <= gbfp_pkg::MODE_PAYLOAD) begin
         sum_a_in = acc_a;
         sum_b_in = sum_b_ff + acc_a;
      end

      unique case (mode_ff)
         gbfp_pkg::MODE_WORD: begin
            if (word_pos_ff < gbfp_pkg::WORD_LEN &&
                rx_byte == gbfp_pkg::word_char(word_pos_ff)) begin
               word_pos_in = word_pos_ff + 3'd1;
               if (word_pos_in == gbfp_pkg::WORD_LEN) begin
                  ev      = gbfp_pkg::EV_WORD;
                  mode_in = gbfp_pkg::MODE_IDLE;
               end
            end else begin
               word_pos_in = 3'd0;
            end
         end
         gbfp_pkg::MODE_SYNC: begin
            if (rx_byte == gbfp_pkg::SYNC_SECOND) begin
               mode_in  = gbfp_pkg::MODE_CLASS;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else begin
               mode_in = gbfp_pkg::MODE_IDLE;
            end
         end
         gbfp_pkg::MODE_CLASS: begin
            class_in = rx_byte;
            mode_in  = gbfp_pkg::MODE_ID;
         end
         gbfp_pkg::MODE_ID: begin
            id_in   = rx_byte;
            mode_in = gbfp_pkg::MODE_LEN_LO;
         end
         gbfp_pkg::MODE_LEN_LO: begin
            len_in  = {8'd0, rx_byte};
            mode_in = gbfp_pkg::MODE_LEN_HI;
         end
         gbfp_pkg::MODE_LEN_HI: begin
            len_in   = {rx_byte, len_ff[7:0]};
            count_in = 16'd0;
            if (len_in > max_len_ff) begin
               ev      = gbfp_pkg::EV_LONG;
               mode_in = gbfp_pkg::MODE_IDLE;
            end else begin
               ev      = gbfp_pkg::EV_HEADER;
               mode_in = (len_in != 16'd0) ? gbfp_pkg::MODE_PAYLOAD : gbfp_pkg::MODE_CK_A;
            end
         end
         gbfp_pkg::MODE_PAYLOAD: begin
            ev       = gbfp_pkg::EV_DATA;
            dbyte    = rx_byte;
            dindex   = count_ff;
            count_in = count_inc;
            if (count_inc == len_ff) begin
               mode_in = gbfp_pkg::MODE_CK_A;
            end
         end
         gbfp_pkg::MODE_CK_A: begin
            if (rx_byte == sum_a_ff) begin
               mode_in = gbfp_pkg::MODE_CK_B;
            end else begin
               ev      = gbfp_pkg::EV_CKA;
               mode_in = gbfp_pkg::MODE_IDLE;
            end
         end
         gbfp_pkg::MODE_CK_B: begin
            ev      = (rx_byte == sum_b_ff) ? gbfp_pkg::EV_OK : gbfp_pkg::EV_CKB;
            mode_in = gbfp_pkg::MODE_IDLE;
         end
         default: begin
            mode_in = (rx_byte == gbfp_pkg::SYNC_FIRST) ? gbfp_pkg::MODE_SYNC
                                                        : gbfp_pkg::MODE_IDLE;
         end
      endcase
   end

   assign result.event_res   = ev;
   assign result.frame_class = class_in;
   assign result.frame_id    = id_in;
   assign result.frame_len   = len_in;
   assign result.data_byte   = dbyte;
   assign result.data_index  = dindex;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= gbfp_pkg::LEN_LIMIT_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= gbfp_pkg::MODE_WORD;
         word_pos_ff <= 3'd0;
         count_ff    <= 16'd0;
         class_ff    <= 8'd0;
         id_ff       <= 8'd0;
         len_ff      <= 16'd0;
         sum_a_ff    <= 8'd0;
         sum_b_ff    <= 8'd0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         word_pos_ff <= word_pos_in;
         count_ff    <= count_in;
         class_ff    <= class_in;
         id_ff       <= id_in;
         len_ff      <= len_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
      end
   end

endmodule

// ===== hdl/gbfp_out_reg.sv =====
module gbfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  gbfp_pkg::result_type result,
   output logic                 advance,
   output logic                 fire,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gbfp_pkg::result_type rsp_data
);

   logic                 valid_ff;
   gbfp_pkg::result_type data_ff;

   assign advance   = !valid_ff || rsp_ready;
   assign fire      = byte_valid && advance;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= byte_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

endmodule
